// ----- rtl/core/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants for the ring fork arbiter.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int SEAT_W     = 3;
	localparam int RING_W     = 4;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [RING_W-1:0] RING_SIZE_RST = 4'd8;

	// register index, taken from paddr[2]
	localparam logic REG_RING_SIZE = 1'b0;

	// action codes
	localparam logic ACT_REQ = 1'b0;
	localparam logic ACT_REL = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_WAIT  = 3'b010,
		PH_GRANT = 3'b100
	} phase_t;

	// per-cell strobes for the current step
	typedef struct packed {
		logic req;     // seat requests: goes waiting unless granted
		logic rel;     // seat releases: goes idle
		logic tryg;    // seat is tried for a grant
		logic set_lm;  // releaser: mark if left neighbor still waits
		logic set_rm;  // releaser: mark if right neighbor still waits
	} cell_ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		phase_t phase;    // phase after this step's request/release
		logic   granted;  // granted in this step
		logic   stuck;    // tried and still waiting
	} nb_t;

	typedef struct packed {
		logic [SEAT_W-1:0] seat;
		logic              last;
	} grant_entry_t;

endpackage

// ----- rtl/core/rfa_cell.sv -----
// ----------------------------------------------------------------------------
// rfa_cell
// One seat of the ring: phase and both starvation marks, with the grant
// test against the two neighboring cells.
// ----------------------------------------------------------------------------
module rfa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              active,
	input  rfa_pkg::cell_ctl_t ctl,
	input  rfa_pkg::nb_t      left_nb,
	input  rfa_pkg::nb_t      right_nb,
	output rfa_pkg::nb_t      nb
);

	rfa_pkg::phase_t phase_q;
	rfa_pkg::phase_t eff_phase;
	logic            lm_q;
	logic            rm_q;
	logic            granted;

	always_comb begin
		if (ctl.rel) begin
			eff_phase = rfa_pkg::PH_IDLE;
		end else if (ctl.req && phase_q != rfa_pkg::PH_GRANT) begin
			eff_phase = rfa_pkg::PH_WAIT;
		end else begin
			eff_phase = phase_q;
		end
	end

	assign granted = ctl.tryg && eff_phase == rfa_pkg::PH_WAIT
		&& left_nb.phase != rfa_pkg::PH_GRANT && right_nb.phase != rfa_pkg::PH_GRANT
		&& !lm_q && !rm_q;

	assign nb.phase   = eff_phase;
	assign nb.granted = granted;
	assign nb.stuck   = ctl.tryg && eff_phase == rfa_pkg::PH_WAIT && !granted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfa_pkg::PH_IDLE;
			lm_q    <= 1'b0;
			rm_q    <= 1'b0;
		end else if (active) begin
			phase_q <= granted ? rfa_pkg::PH_GRANT : eff_phase;
			if (left_nb.granted) begin
				lm_q <= 1'b0;
			end else if (ctl.set_lm && left_nb.stuck) begin
				lm_q <= 1'b1;
			end
			if (right_nb.granted) begin
				rm_q <= 1'b0;
			end else if (ctl.set_rm && right_nb.stuck) begin
				rm_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/rfa_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rfa_out_fifo
// Four-entry grant queue; takes up to two entries per cycle, gives one.
// ----------------------------------------------------------------------------
module rfa_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push0,
	input  rfa_pkg::grant_entry_t  entry0,
	input  logic                   push1,
	input  rfa_pkg::grant_entry_t  entry1,
	output logic                   rd_valid,
	input  logic                   rd_ready,
	output rfa_pkg::grant_entry_t  rd_entry,
	output logic                   room2
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	rfa_pkg::grant_entry_t mem_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         n_push;
	logic                  pop;

	assign pop      = rd_valid && rd_ready;
	assign n_push   = CW'(push0) + CW'(push1);
	assign rd_valid = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];
	assign room2    = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= entry0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + PW'(1)] <= entry1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + n_push - CW'(pop);
		end
	end

endmodule

// ----- rtl/core/ring_fork_arbiter_fair.sv -----
// ----------------------------------------------------------------------------
// ring_fork_arbiter_fair
// Fair ring arbiter: each seat shares a resource with both neighbors and is
// granted only when neither neighbor holds it and no starvation mark blocks it.
// ----------------------------------------------------------------------------
// An accepted request or release passes the input skid register and the
// execution register, and its grants go into the grant queue. A release tries
// its left and then its right neighbor on the shared row of seat cells, one
// per cycle while the grant queue has room for two entries.
// Reset: all seats idle, all marks clear, ring_size 8, grant queue empty.
// ----------------------------------------------------------------------------
module ring_fork_arbiter_fair #(
	parameter int MAX_SEATS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rfa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rfa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// requests and releases
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             action,
	input  logic [rfa_pkg::SEAT_W-1:0]       seat,
	// grants
	output logic                             grant_valid,
	input  logic                             grant_ready,
	output logic [rfa_pkg::SEAT_W-1:0]       grant_seat,
	output logic                             last_grant
);

	localparam int SW = $clog2(MAX_SEATS);
	localparam int NW = $clog2(MAX_SEATS + 1);

	typedef enum logic [1:0] {
		STEP_A = 2'b01,
		STEP_B = 2'b10
	} step_t;

	// config
	logic [rfa_pkg::RING_W-1:0] ring_size_q;
	logic [NW-1:0]              used_n;
	logic [SW-1:0]              last_idx;

	// input skid
	logic                        buf_valid_q;
	logic                        buf_action_q;
	logic [rfa_pkg::SEAT_W-1:0]  buf_seat_q;

	// execution
	logic                        exec_valid_q;
	logic                        exec_action_q;
	logic [rfa_pkg::SEAT_W-1:0]  exec_seat_q;
	step_t                       step_q;
	logic                        pend_valid_q;
	logic [rfa_pkg::SEAT_W-1:0]  pend_seat_q;

	logic          exec_go;
	logic          exec_done;
	logic          exec_load;
	logic          in_range;
	logic          req_step;
	logic          rel_a;
	logic          rel_b;
	logic [SW-1:0] p_idx;
	logic [SW-1:0] l_idx;
	logic [SW-1:0] r_idx;

	// cells
	rfa_pkg::cell_ctl_t    cell_ctl [MAX_SEATS];
	rfa_pkg::nb_t          cell_nb  [MAX_SEATS];
	logic [MAX_SEATS-1:0]  grant_vec;
	logic                  any_grant;
	logic [SW-1:0]         grant_idx;
	logic [rfa_pkg::SEAT_W-1:0] g_seat;

	// queue
	logic                  push0;
	logic                  push1;
	rfa_pkg::grant_entry_t entry0;
	rfa_pkg::grant_entry_t entry1;
	rfa_pkg::grant_entry_t rd_entry;
	logic                  room2;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == rfa_pkg::REG_RING_SIZE) begin
			prdata = rfa_pkg::APB_DATA_W'(ring_size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= rfa_pkg::RING_SIZE_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == rfa_pkg::REG_RING_SIZE) begin
			ring_size_q <= pwdata[rfa_pkg::RING_W-1:0];
		end
	end

	always_comb begin
		if (int'(ring_size_q) < 2) begin
			used_n = NW'(2);
		end else if (int'(ring_size_q) > MAX_SEATS) begin
			used_n = NW'(MAX_SEATS);
		end else begin
			used_n = NW'(ring_size_q);
		end
	end

	assign last_idx = SW'(used_n - NW'(1));

	// ---------------- input skid and sequencing ----------------
	assign in_range  = int'(exec_seat_q) < int'(used_n);
	assign exec_go   = exec_valid_q && room2;
	assign req_step  = exec_go && in_range && exec_action_q == rfa_pkg::ACT_REQ;
	assign rel_a     = exec_go && in_range && exec_action_q == rfa_pkg::ACT_REL
		&& step_q == STEP_A;
	assign rel_b     = exec_go && in_range && exec_action_q == rfa_pkg::ACT_REL
		&& step_q == STEP_B;
	assign exec_done = exec_go && !rel_a;
	assign exec_load = buf_valid_q && (!exec_valid_q || exec_done);
	assign item_ready = !buf_valid_q || exec_load;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			buf_action_q <= action;
			buf_seat_q   <= seat;
		end
		if (exec_load) begin
			exec_action_q <= buf_action_q;
			exec_seat_q   <= buf_seat_q;
		end
		if (rel_a) begin
			pend_seat_q <= g_seat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q  <= 1'b0;
			exec_valid_q <= 1'b0;
			step_q       <= STEP_A;
			pend_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				buf_valid_q <= 1'b1;
			end else if (exec_load) begin
				buf_valid_q <= 1'b0;
			end
			if (exec_load) begin
				exec_valid_q <= 1'b1;
				step_q       <= STEP_A;
			end else if (exec_done) begin
				exec_valid_q <= 1'b0;
				step_q       <= STEP_A;
			end else if (rel_a) begin
				step_q <= STEP_B;
			end
			if (rel_a) begin
				pend_valid_q <= any_grant;
			end else if (exec_done) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- seat targets ----------------
	assign p_idx = SW'(exec_seat_q);
	assign l_idx = (p_idx == '0) ? last_idx : p_idx - SW'(1);
	assign r_idx = (int'(p_idx) + 1 == int'(used_n)) ? '0 : p_idx + SW'(1);

	always_comb begin
		for (int i = 0; i < MAX_SEATS; i++) begin
			cell_ctl[i].req    = req_step && p_idx == SW'(i);
			cell_ctl[i].rel    = rel_a && p_idx == SW'(i);
			cell_ctl[i].tryg   = (req_step && p_idx == SW'(i))
				|| (rel_a && l_idx == SW'(i)) || (rel_b && r_idx == SW'(i));
			cell_ctl[i].set_lm = rel_a && p_idx == SW'(i);
			cell_ctl[i].set_rm = rel_b && p_idx == SW'(i);
		end
	end

	// ---------------- row of seat cells ----------------
	for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
		rfa_pkg::nb_t left_in;
		rfa_pkg::nb_t right_in;

		if (i == 0) begin : g_left_wrap
			assign left_in = cell_nb[last_idx];
		end else begin : g_left
			assign left_in = cell_nb[i-1];
		end

		if (i == MAX_SEATS - 1) begin : g_right_wrap
			assign right_in = cell_nb[0];
		end else begin : g_right
			assign right_in = (i + 1 == int'(used_n)) ? cell_nb[0] : cell_nb[i+1];
		end

		rfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.active   (i < int'(used_n)),
			.ctl      (cell_ctl[i]),
			.left_nb  (left_in),
			.right_nb (right_in),
			.nb       (cell_nb[i])
		);

		assign grant_vec[i] = cell_nb[i].granted;
	end

	always_comb begin
		grant_idx = '0;
		for (int i = 0; i < MAX_SEATS; i++) begin
			if (grant_vec[i]) begin
				grant_idx = grant_idx | SW'(i);
			end
		end
	end

	assign any_grant = |grant_vec;
	assign g_seat    = rfa_pkg::SEAT_W'(grant_idx);

	// ---------------- result queue ----------------
	always_comb begin
		push0       = 1'b0;
		push1       = 1'b0;
		entry0.seat = g_seat;
		entry0.last = 1'b1;
		entry1.seat = g_seat;
		entry1.last = 1'b1;
		if (req_step) begin
			push0 = any_grant;
		end else if (rel_b) begin
			if (pend_valid_q) begin
				push0       = 1'b1;
				entry0.seat = pend_seat_q;
				entry0.last = !any_grant;
				push1       = any_grant;
			end else begin
				push0 = any_grant;
			end
		end
	end

	rfa_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (push0),
		.entry0   (entry0),
		.push1    (push1),
		.entry1   (entry1),
		.rd_valid (grant_valid),
		.rd_ready (grant_ready),
		.rd_entry (rd_entry),
		.room2    (room2)
	);

	assign grant_seat = rd_entry.seat;
	assign last_grant = rd_entry.last;

	// ---------------- assertions ----------------
	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vec))
		else $error("more than one seat granted in a step");

	a_grant_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		any_grant |-> exec_go && in_range)
		else $error("grant outside an executing step");

	a_step_b_release: assert property (@(posedge clk) disable iff (!arst_n)
		exec_valid_q && step_q == STEP_B |-> exec_action_q == rfa_pkg::ACT_REL)
		else $error("second step on a request");

	a_pend_in_step_b: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> exec_valid_q && step_q == STEP_B)
		else $error("held grant outside second release step");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fair ring fork arbiter. Requests and releases
// go in through a queue-fed driver with random gaps, and grants come out to a
// monitor with random back-pressure and one long hold-off. Each grant is
// checked against a cycle-free model of the seat ring. The ring size is
// rewritten over APB between phases, including out-of-range values.
// ----------------------------------------------------------------------------
module tb;

	localparam int SEATS           = 8;
	localparam int ITEMS_PER_PHASE = 156;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_AFTER      = 300;
	localparam int HOLD_CYCLES     = 400;

	typedef struct packed {
		logic                       act;
		logic [rfa_pkg::SEAT_W-1:0] seat;
	} seat_cmd_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           psel        = 1'b0;
	logic                           penable     = 1'b0;
	logic                           pwrite      = 1'b0;
	logic [rfa_pkg::APB_ADDR_W-1:0] paddr       = '0;
	logic [rfa_pkg::APB_DATA_W-1:0] pwdata      = '0;
	logic [rfa_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           item_valid  = 1'b0;
	logic                           item_ready;
	logic                           action      = 1'b0;
	logic [rfa_pkg::SEAT_W-1:0]     seat        = '0;
	logic                           grant_valid;
	logic                           grant_ready = 1'b0;
	logic [rfa_pkg::SEAT_W-1:0]     grant_seat;
	logic                           last_grant;

	ring_fork_arbiter_fair #(.MAX_SEATS(SEATS)) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.action      (action),
		.seat        (seat),
		.grant_valid (grant_valid),
		.grant_ready (grant_ready),
		.grant_seat  (grant_seat),
		.last_grant  (last_grant)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ring model
	rfa_pkg::phase_t            seat_ph [SEATS];
	logic                       lmark   [SEATS];
	logic                       rmark   [SEATS];
	logic [rfa_pkg::RING_W-1:0] ring_cfg = rfa_pkg::RING_SIZE_RST;

	rfa_pkg::grant_entry_t grant_q[$];
	seat_cmd_t             pending_q[$];
	logic                  want_on [SEATS];

	int   err_cnt      = 0;
	int   accepted_cnt = 0;
	int   cycle_cnt    = 0;
	logic burst        = 1'b0;
	logic hold_off     = 1'b0;

	task automatic report_mismatch(string msg);
		$display("ERROR @%0d: %s", cycle_cnt, msg);
		err_cnt++;
	endtask

	function automatic int seats_in_use();
		if (ring_cfg < 2) return 2;
		if (ring_cfg > SEATS) return SEATS;
		return int'(ring_cfg);
	endfunction

	function automatic bit grant_try(int p, int n);
		int l;
		int r;
		l = (p + n - 1) % n;
		r = (p + 1) % n;
		if (seat_ph[p] != rfa_pkg::PH_WAIT) return 1'b0;
		if (seat_ph[l] == rfa_pkg::PH_GRANT || seat_ph[r] == rfa_pkg::PH_GRANT) return 1'b0;
		if (lmark[p] || rmark[p]) return 1'b0;
		seat_ph[p] = rfa_pkg::PH_GRANT;
		rmark[l] = 1'b0;
		lmark[r] = 1'b0;
		return 1'b1;
	endfunction

	task automatic arb_apply(seat_cmd_t c);
		int                    n;
		int                    p;
		int                    l;
		int                    r;
		int                    won[$];
		rfa_pkg::grant_entry_t g;
		n = seats_in_use();
		p = int'(c.seat);
		if (p >= n) return;
		l = (p + n - 1) % n;
		r = (p + 1) % n;
		if (c.act == rfa_pkg::ACT_REQ) begin
			if (seat_ph[p] != rfa_pkg::PH_GRANT) begin
				seat_ph[p] = rfa_pkg::PH_WAIT;
				if (grant_try(p, n)) won.push_back(p);
			end
		end else begin
			seat_ph[p] = rfa_pkg::PH_IDLE;
			if (grant_try(l, n)) won.push_back(l);
			if (seat_ph[l] == rfa_pkg::PH_WAIT) lmark[p] = 1'b1;
			if (grant_try(r, n)) won.push_back(r);
			if (seat_ph[r] == rfa_pkg::PH_WAIT) rmark[p] = 1'b1;
		end
		foreach (won[i]) begin
			g.seat = rfa_pkg::SEAT_W'(won[i]);
			g.last = (i == won.size() - 1);
			grant_q.push_back(g);
		end
	endtask

	function automatic seat_cmd_t seat_cmd(logic act, int s);
		seat_cmd_t c;
		c.act  = act;
		c.seat = rfa_pkg::SEAT_W'(s);
		return c;
	endfunction

	// driver
	int        tx_gap = 0;
	seat_cmd_t tx_cur;
	seat_cmd_t tx_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (item_valid && item_ready) begin
				tx_cur.act  = action;
				tx_cur.seat = seat;
				arb_apply(tx_cur);
				accepted_cnt++;
			end
			if (!item_valid || item_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					item_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					tx_next = pending_q.pop_front();
					action     <= tx_next.act;
					seat       <= tx_next.seat;
					item_valid <= 1'b1;
					tx_gap = burst ? 0 : $urandom_range(0, 3);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int                    rx_wait = 0;
	rfa_pkg::grant_entry_t rx_exp;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (grant_valid && grant_ready) begin
				if (grant_q.size() == 0) begin
					report_mismatch($sformatf("unexpected grant seat %0d last %0b",
						grant_seat, last_grant));
				end else begin
					rx_exp = grant_q.pop_front();
					if (grant_seat !== rx_exp.seat)
						report_mismatch($sformatf("grant_seat %0d, want %0d",
							grant_seat, rx_exp.seat));
					if (last_grant !== rx_exp.last)
						report_mismatch($sformatf("last_grant %0b, want %0b (seat %0d)",
							last_grant, rx_exp.last, rx_exp.seat));
				end
				rx_wait = burst ? 0 : $urandom_range(0, 3);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				grant_ready <= 1'b0;
			end else begin
				grant_ready <= !hold_off;
			end
		end
	end

	// long receiver hold-off so the grant path backs up into the input
	initial begin
		while (accepted_cnt < HOLD_AFTER) @(negedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic ring_write(logic [rfa_pkg::RING_W-1:0] v);
		logic [rfa_pkg::APB_DATA_W-1:0] wd;
		wd      = $urandom;
		wd[rfa_pkg::RING_W-1:0] = v;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {rfa_pkg::REG_RING_SIZE, 2'b00};
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		ring_cfg = v;
	endtask

	task automatic ring_check();
		logic [rfa_pkg::APB_DATA_W-1:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {rfa_pkg::REG_RING_SIZE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== rfa_pkg::APB_DATA_W'(ring_cfg))
			report_mismatch($sformatf("ring_size reads %0h, want %0h", rd, ring_cfg));
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || item_valid || grant_q.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic fill_random(int count);
		int        n;
		int        s;
		seat_cmd_t c;
		n = seats_in_use();
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) s = $urandom_range(0, SEATS - 1);
			else s = $urandom_range(0, n - 1);
			c.seat = rfa_pkg::SEAT_W'(s);
			if ($urandom_range(0, 6) == 0) c.act = 1'($urandom_range(0, 1));
			else c.act = want_on[s] ? rfa_pkg::ACT_REL : rfa_pkg::ACT_REQ;
			want_on[s] = (c.act == rfa_pkg::ACT_REQ);
			pending_q.push_back(c);
		end
	endtask

	logic [rfa_pkg::RING_W-1:0] ring_plan [12] = '{4'd8, 4'd2, 4'd3, 4'd5, 4'd7, 4'd0,
	                                                4'd1, 4'd15, 4'd9, 4'd4, 4'd6, 4'd8};

	initial begin
		foreach (seat_ph[i]) begin
			seat_ph[i] = rfa_pkg::PH_IDLE;
			lmark[i]   = 1'b0;
			rmark[i]   = 1'b0;
			want_on[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		ring_check();

		// eight seats at reset size: grants, blocking, marks
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 0));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 1));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 7));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 0));  // already granted
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 1));  // still waiting
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 0));  // wakes both neighbors
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 3));  // release without grant
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 2));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 1));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 3));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 4));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 2));  // marks releaser
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 2));  // blocked by its mark
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 4));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 3));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 2));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 7));
		drain();

		// two-seat ring, seats outside the ring
		ring_write(4'd2);
		ring_check();
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 0));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 1));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 0));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 0));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 1));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 0));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REQ, 5));
		pending_q.push_back(seat_cmd(rfa_pkg::ACT_REL, 7));
		drain();

		foreach (ring_plan[k]) begin
			ring_write(ring_plan[k]);
			ring_check();
			burst <= (k % 4 == 3);
			fill_random(ITEMS_PER_PHASE);
			drain();
		end

		if (grant_q.size() != 0)
			report_mismatch($sformatf("%0d grants never seen", grant_q.size()));
		if (err_cnt == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
